FILE: src/twkd_pkg.sv
// ----------------------------------------------------------------------------
// twkd_pkg
// Shared types, codes and lookup tables of the keyboard bus word decoder.
// ----------------------------------------------------------------------------
package twkd_pkg;

  // Bus words that open and classify a command sequence
  localparam logic [8:0] CMD_START = 9'h121;
  localparam logic [8:0] SEQ_CHAR  = 9'h003;
  localparam logic [8:0] SEQ_VERT  = 9'h005;
  localparam logic [8:0] SEQ_HORIZ = 9'h006;
  localparam logic [8:0] SEQ_CODE  = 9'h00E;

  // Highest printwheel code that the table covers
  localparam logic [8:0] WHEEL_LAST = 9'd96;
  localparam int unsigned WHEEL_DEPTH = 97;

  localparam logic [7:0] CH_NONE = 8'h00;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_HT   = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;

  localparam logic [7:0] SPC_RESET = 8'd10;
  localparam logic [4:0] LPL_RESET = 5'd16;

  typedef enum logic [1:0] {
    REG_SPACES_PER_CHAR = 2'd0,
    REG_LINES_PER_LINE  = 2'd1,
    REG_LOCAL_MODE      = 2'd2
  } cfg_reg_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CMD   = 9'b000000010,
    ST_CHAR1 = 9'b000000100,
    ST_CHAR2 = 9'b000001000,
    ST_VERT  = 9'b000010000,
    ST_HORIZ = 9'b000100000,
    ST_RIGHT = 9'b001000000,
    ST_LEFT  = 9'b010000000,
    ST_CODE  = 9'b100000000
  } seq_state_t;

  typedef struct packed {
    logic [7:0] spaces_per_char;
    logic [4:0] lines_per_line;
    logic       local_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] key_char;
    logic       forward_vertical;
    logic [8:0] vertical_word;
  } result_t;

  localparam logic [7:0] WHEEL_ROM [WHEEL_DEPTH] = '{
    8'h20,8'h61,8'h6E,8'h72,8'h6D,8'h63,8'h73,8'h64,8'h68,8'h6C,8'h66,8'h6B,8'h2C,8'h56,
    8'h2D,8'h47,8'h55,8'h46,8'h42,8'h5A,8'h48,8'h50,8'h29,8'h52,8'h4C,8'h53,8'h4E,8'h43,
    8'h54,8'h44,8'h45,8'h49,8'h41,8'h4A,8'h4F,8'h28,8'h4D,8'h3E,8'h59,8'h3C,8'h2F,8'h57,
    8'h39,8'h4B,8'h33,8'h58,8'h31,8'h32,8'h30,8'h35,8'h34,8'h36,8'h38,8'h37,8'h2A,8'h24,
    8'h23,8'h25,8'h5E,8'h2B,8'h60,8'h40,8'h51,8'h26,8'h5D,8'h7D,8'h5C,8'h7C,8'h7E,8'h00,
    8'h00,8'h5B,8'h7B,8'h21,8'h3F,8'h22,8'h27,8'h3D,8'h3A,8'h5F,8'h3B,8'h78,8'h71,8'h76,
    8'h7A,8'h77,8'h6A,8'h2E,8'h79,8'h62,8'h67,8'h75,8'h70,8'h69,8'h74,8'h6F,8'h65
  };

  // Code-key combinations; Code+Erase gives the mode toggle 0xF0
  function automatic logic [7:0] code_key_char(input logic [6:0] key);
    logic [7:0] ch;
    case (key)
      7'h02:   ch = 8'h11;
      7'h04:   ch = 8'h01;
      7'h06:   ch = 8'h1A;
      7'h0A:   ch = 8'h17;
      7'h0C:   ch = 8'h13;
      7'h0E:   ch = 8'h18;
      7'h12:   ch = 8'h05;
      7'h14:   ch = 8'h04;
      7'h16:   ch = 8'h03;
      7'h1A:   ch = 8'h12;
      7'h1B:   ch = 8'h14;
      7'h1C:   ch = 8'h06;
      7'h1D:   ch = 8'h07;
      7'h1E:   ch = 8'h16;
      7'h1F:   ch = 8'h02;
      7'h22:   ch = 8'h15;
      7'h23:   ch = 8'h19;
      7'h24:   ch = 8'h0A;
      7'h25:   ch = 8'h08;
      7'h26:   ch = 8'h0D;
      7'h2A:   ch = 8'h09;
      7'h2C:   ch = 8'h0B;
      7'h32:   ch = 8'h0F;
      7'h34:   ch = 8'h0C;
      7'h3A:   ch = 8'h10;
      7'h48:   ch = 8'h1B;
      7'h4F:   ch = 8'hF0;
      7'h76:   ch = 8'h0E;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

FILE: src/typewriter_key_word_decoder_top.sv
// ----------------------------------------------------------------------------
// typewriter_key_word_decoder_top
// Keyboard bus word decoder: tracks command sequences, emits one character
// (or 0) per word, flags vertical moves for pass-through in local mode.
//
//   channel | dir | handshake           | payload
//   in      | in  | in_valid/in_ready   | in_bus_word[8:0]
//   out     | out | out_valid/out_ready | out_key_char, out_forward_vertical,
//           |     |                     | out_vertical_word
//   cfg     | in  | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[7:0]
//
// One item per cycle while out_ready holds; input register, decode, result
// register. Decode is a single level of state-machine and table logic.
// Synchronous active-low reset clears sequence state and loads config defaults.
// Output stall holds the result register; the input register drains into it
// as soon as it frees up, so in_ready drops only while both are full.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module typewriter_key_word_decoder_top
  import twkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] in_bus_word,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_key_char,
  output logic       out_forward_vertical,
  output logic [8:0] out_vertical_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t    cfg_q;
  result_t dec_res;
  result_t res_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic [8:0] s1_word_r;
  logic       out_valid_r, out_valid_nxt;
  logic       advance;
  logic       in_fire;

  assign cfg_ready = 1'b1;

  twkd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg_q)
  );

  twkd_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .word    (s1_word_r),
    .cfg     (cfg_q),
    .res     (dec_res)
  );

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)      s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance)        out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_word_r <= in_bus_word;
    if (advance) res_r     <= dec_res;
  end

  assign out_valid            = out_valid_r;
  assign out_key_char         = res_r.key_char;
  assign out_forward_vertical = res_r.forward_vertical;
  assign out_vertical_word    = res_r.vertical_word;

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input blocked while result register empty");

  a_stall_only_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without output backpressure");

  a_fwd_needs_local: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.forward_vertical) |-> cfg_q.local_mode)
    else $error("vertical forward outside local mode");

  a_vword_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.forward_vertical) |-> (res_r.vertical_word == 9'd0))
    else $error("vertical word set without forward flag");

endmodule

FILE: src/twkd_cfg_regs.sv
// ----------------------------------------------------------------------------
// twkd_cfg_regs
// Configuration register file: pitch, line height and local mode.
// ----------------------------------------------------------------------------
module twkd_cfg_regs
  import twkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_SPACES_PER_CHAR: cfg_nxt.spaces_per_char = wr_data;
        REG_LINES_PER_LINE:  cfg_nxt.lines_per_line  = wr_data[4:0];
        REG_LOCAL_MODE:      cfg_nxt.local_mode      = wr_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spaces_per_char <= SPC_RESET;
      cfg_r.lines_per_line  <= LPL_RESET;
      cfg_r.local_mode      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/twkd_decode.sv
// ----------------------------------------------------------------------------
// twkd_decode
// Sequence tracker and per-word character decode.
// ----------------------------------------------------------------------------
module twkd_decode
  import twkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [8:0] word,
  input  cfg_t       cfg,
  output result_t    res
);

  seq_state_t state_r, state_nxt;
  logic [8:0] prev_r;
  logic [11:0] spc_ext;
  logic [11:0] spc_x10;
  logic [11:0] word_ext;

  assign spc_ext  = {4'b0, cfg.spaces_per_char};
  assign spc_x10  = (spc_ext << 3) + (spc_ext << 1);
  assign word_ext = {3'b0, word};

  always_comb begin
    state_nxt = ST_IDLE;
    res       = '0;
    case (state_r)
      ST_IDLE: begin
        if (word == CMD_START) state_nxt = ST_CMD;
      end
      ST_CMD: begin
        if (word == SEQ_CHAR)       state_nxt = ST_CHAR1;
        else if (word == SEQ_VERT)  state_nxt = ST_VERT;
        else if (word == SEQ_HORIZ) state_nxt = ST_HORIZ;
        else if (word == SEQ_CODE)  state_nxt = ST_CODE;
      end
      ST_CHAR1: state_nxt = ST_CHAR2;
      ST_CHAR2: begin
        // printwheel code arrived one word earlier
        if (prev_r <= WHEEL_LAST) res.key_char = WHEEL_ROM[prev_r[6:0]];
      end
      ST_VERT: begin
        if (word[4:0] == cfg.lines_per_line && word[7]) res.key_char = CH_CR;
        if (cfg.local_mode) begin
          res.forward_vertical = 1'b1;
          res.vertical_word    = word;
        end
      end
      ST_HORIZ: state_nxt = word[7] ? ST_RIGHT : ST_LEFT;
      ST_RIGHT: begin
        if (word_ext > spc_ext && word_ext < spc_x10) res.key_char = CH_HT;
        else if (word_ext == spc_ext)                 res.key_char = CH_SP;
      end
      ST_LEFT: begin
        if (word_ext == spc_ext) res.key_char = CH_BS;
      end
      ST_CODE: res.key_char = code_key_char(word[6:0]);
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      prev_r  <= word;
    end
  end

endmodule

FILE: tb/sv/typewriter_key_word_decoder_checker.sv
// ----------------------------------------------------------------------------
// typewriter_key_word_decoder_checker
// Watches the bus word, result and register channels of the key word decoder,
// decodes every accepted bus word itself and compares each delivered result,
// field by field, with the oldest decoded character still waiting.
// ----------------------------------------------------------------------------
module typewriter_key_word_decoder_checker
  import twkd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [8:0]  in_bus_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_key_char,
  input  logic        out_forward_vertical,
  input  logic [8:0]  out_vertical_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        drain_done,
  output int unsigned fail_count,
  output int unsigned chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PRINTED = 40;

  // Printwheel position to ASCII
  localparam logic [7:0] WHEEL_ASCII [0:96] = '{
    8'h20, 8'h61, 8'h6E, 8'h72, 8'h6D, 8'h63, 8'h73, 8'h64, 8'h68, 8'h6C, 8'h66, 8'h6B,
    8'h2C, 8'h56, 8'h2D, 8'h47, 8'h55, 8'h46, 8'h42, 8'h5A, 8'h48, 8'h50, 8'h29, 8'h52,
    8'h4C, 8'h53, 8'h4E, 8'h43, 8'h54, 8'h44, 8'h45, 8'h49, 8'h41, 8'h4A, 8'h4F, 8'h28,
    8'h4D, 8'h3E, 8'h59, 8'h3C, 8'h2F, 8'h57, 8'h39, 8'h4B, 8'h33, 8'h58, 8'h31, 8'h32,
    8'h30, 8'h35, 8'h34, 8'h36, 8'h38, 8'h37, 8'h2A, 8'h24, 8'h23, 8'h25, 8'h5E, 8'h2B,
    8'h60, 8'h40, 8'h51, 8'h26, 8'h5D, 8'h7D, 8'h5C, 8'h7C, 8'h7E, 8'h00, 8'h00, 8'h5B,
    8'h7B, 8'h21, 8'h3F, 8'h22, 8'h27, 8'h3D, 8'h3A, 8'h5F, 8'h3B, 8'h78, 8'h71, 8'h76,
    8'h7A, 8'h77, 8'h6A, 8'h2E, 8'h79, 8'h62, 8'h67, 8'h75, 8'h70, 8'h69, 8'h74, 8'h6F,
    8'h65
  };

  cfg_t       regs;
  seq_state_t seq;
  logic [8:0] last_word;
  result_t    char_q[$];
  bit         end_checked;

  function automatic logic [7:0] code_key_ascii(input logic [6:0] key);
    logic [7:0] ch;
    case (key)
      7'h02:   ch = 8'h11;
      7'h04:   ch = 8'h01;
      7'h06:   ch = 8'h1A;
      7'h0A:   ch = 8'h17;
      7'h0C:   ch = 8'h13;
      7'h0E:   ch = 8'h18;
      7'h12:   ch = 8'h05;
      7'h14:   ch = 8'h04;
      7'h16:   ch = 8'h03;
      7'h1A:   ch = 8'h12;
      7'h1B:   ch = 8'h14;
      7'h1C:   ch = 8'h06;
      7'h1D:   ch = 8'h07;
      7'h1E:   ch = 8'h16;
      7'h1F:   ch = 8'h02;
      7'h22:   ch = 8'h15;
      7'h23:   ch = 8'h19;
      7'h24:   ch = 8'h0A;
      7'h25:   ch = 8'h08;
      7'h26:   ch = 8'h0D;
      7'h2A:   ch = 8'h09;
      7'h2C:   ch = 8'h0B;
      7'h32:   ch = 8'h0F;
      7'h34:   ch = 8'h0C;
      7'h3A:   ch = 8'h10;
      7'h48:   ch = 8'h1B;
      7'h4F:   ch = 8'hF0;
      7'h76:   ch = 8'h0E;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

  // Advances the sequence tracker by one bus word and returns its character
  function automatic result_t decode_bus_word(input logic [8:0] w);
    result_t     r;
    seq_state_t  nxt;
    int unsigned pitch;
    r = '0;
    nxt = ST_IDLE;
    pitch = regs.spaces_per_char;
    case (seq)
      ST_IDLE: begin
        if (w == CMD_START) nxt = ST_CMD;
      end
      ST_CMD: begin
        case (w)
          SEQ_CHAR:  nxt = ST_CHAR1;
          SEQ_VERT:  nxt = ST_VERT;
          SEQ_HORIZ: nxt = ST_HORIZ;
          SEQ_CODE:  nxt = ST_CODE;
          default:   nxt = ST_IDLE;
        endcase
      end
      ST_CHAR1: nxt = ST_CHAR2;
      // wheel code came one word earlier, this word is the space count
      ST_CHAR2: begin
        if (last_word <= WHEEL_LAST) r.key_char = WHEEL_ASCII[last_word];
      end
      ST_VERT: begin
        if (w[4:0] == regs.lines_per_line && w[7]) r.key_char = CH_CR;
        if (regs.local_mode) begin
          r.forward_vertical = 1'b1;
          r.vertical_word = w;
        end
      end
      ST_HORIZ: nxt = w[7] ? ST_RIGHT : ST_LEFT;
      ST_RIGHT: begin
        if (w > pitch && w < pitch * 10) r.key_char = CH_HT;
        else if (w == pitch) r.key_char = CH_SP;
      end
      ST_LEFT: begin
        if (w == pitch) r.key_char = CH_BS;
      end
      ST_CODE: r.key_char = code_key_ascii(w[6:0]);
      default: nxt = ST_IDLE;
    endcase
    seq = nxt;
    last_word = w;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < MAX_PRINTED)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      regs.spaces_per_char = SPC_RESET;
      regs.lines_per_line = LPL_RESET;
      regs.local_mode = 1'b0;
      seq = ST_IDLE;
      last_word = '0;
      char_q.delete();
      fail_count = 0;
      end_checked = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPACES_PER_CHAR: regs.spaces_per_char = cfg_data;
          REG_LINES_PER_LINE:  regs.lines_per_line = cfg_data[4:0];
          REG_LOCAL_MODE:      regs.local_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (char_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_key_char, 0);
        end else begin
          want = char_q.pop_front();
          if (out_key_char !== want.key_char)
            report_mismatch("key_char", out_key_char, want.key_char);
          if (out_forward_vertical !== want.forward_vertical)
            report_mismatch("forward_vertical", out_forward_vertical,
                            want.forward_vertical);
          if (out_vertical_word !== want.vertical_word)
            report_mismatch("vertical_word", out_vertical_word, want.vertical_word);
        end
      end
      if (in_valid && in_ready) char_q.push_back(decode_bus_word(in_bus_word));
      if (drain_done && !end_checked) begin
        end_checked = 1'b1;
        if (char_q.size() != 0)
          report_mismatch("results never delivered", char_q.size(), 0);
      end
    end
    chars_pending = char_q.size();
  end

endmodule

FILE: tb/sv/typewriter_key_word_decoder_top_test.sv
// ----------------------------------------------------------------------------
// typewriter_key_word_decoder_top_test
// Drives keyboard bus words through the key word decoder: a few corner
// sequences, then register settings with mostly well-formed random command
// sequences, bursty input and a stalling result side. The checker decodes
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module typewriter_key_word_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import twkd_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 60;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int RANDOM_PHASES   = 6;
  localparam int SETTLE_CYCLES   = 4;

  // index with no register behind it; writes must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [8:0] KEY_ERASE  = 9'h04F;
  localparam logic [8:0] SPC_WORD   = {1'b0, SPC_RESET};

  localparam logic [8:0] CORNER_WORDS [24] = '{
    CMD_START, SEQ_CHAR, 9'h000, SPC_WORD,               // wheel code 0
    CMD_START, SEQ_CHAR, WHEEL_LAST + 9'd1, 9'h1FF,      // code past the table
    CMD_START, SEQ_VERT, {4'b0100, LPL_RESET},           // one full line: CR
    CMD_START, SEQ_HORIZ, 9'h080, SPC_WORD,              // right one pitch: SP
    CMD_START, SEQ_HORIZ, 9'h000, SPC_WORD,              // left one pitch: BS
    CMD_START, SEQ_CODE, {2'b11, KEY_ERASE[6:0]},        // Code+Erase, top bits set
    CMD_START, 9'h1FF                                    // unknown kind
  };

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [8:0]  in_bus_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_key_char;
  logic        out_forward_vertical;
  logic [8:0]  out_vertical_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        drain_done = 1'b0;
  int unsigned fail_count;
  int unsigned chars_pending;

  logic [7:0]  cur_spc;
  logic [4:0]  cur_lpl;
  int          burst_left;
  bit          steady;
  int          word_count;
  int          hold_cnt = 0;
  int          cycle_count = 0;

  typewriter_key_word_decoder_top i_dut (.*);

  typewriter_key_word_decoder_checker i_checker (.*);

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: changing stall patterns, plus a long hold-off on request
  always @(posedge clk) begin
    int       hold_left;
    int       holds_seen;
    int       mode_left;
    int       tick;
    rx_mode_t mode;
    tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_cnt != holds_seen) begin
      holds_seen = hold_cnt;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end else begin
        mode_left--;
      end
      case (mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (tick % 4 == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic push_word(input logic [8:0] w);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_bus_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    word_count++;
  endtask

  // Stop sending and let every outstanding character come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] spc, input logic [7:0] lpl,
                          input logic local_on);
    write_reg(REG_SPACES_PER_CHAR, spc);
    write_reg(REG_LINES_PER_LINE, lpl);
    write_reg(REG_LOCAL_MODE, {7'($urandom_range(0, 127)), local_on});
    cfg_valid <= 1'b0;
    cur_spc = spc;
    cur_lpl = lpl[4:0];
  endtask

  // Space counts near the pitch boundaries, or anything
  function automatic logic [8:0] pick_space_count();
    int unsigned pitch;
    int unsigned n;
    pitch = cur_spc;
    case ($urandom_range(0, 7))
      0:       n = pitch - 1;
      1, 2:    n = pitch;
      3:       n = pitch + 1;
      4:       n = pitch * 10 - 1;
      5:       n = pitch * 10;
      6:       n = $urandom_range(pitch + 1, pitch * 10 - 1);
      default: n = $urandom_range(0, 511);
    endcase
    return n[8:0];
  endfunction

  task automatic send_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 88) push_word(CMD_START);
    if (kind < 20) begin
      push_word(SEQ_CHAR);
      push_word(9'(($urandom_range(0, 4) != 0) ? $urandom_range(0, WHEEL_LAST)
                                               : $urandom_range(WHEEL_LAST + 1, 511)));
      push_word(($urandom_range(0, 1) != 0) ? pick_space_count()
                                            : 9'($urandom_range(0, 511)));
    end else if (kind < 35) begin
      push_word(SEQ_VERT);
      push_word(($urandom_range(0, 1) != 0)
                ? {1'($urandom_range(0, 1)), 1'b1, 2'($urandom_range(0, 3)), cur_lpl}
                : 9'($urandom_range(0, 511)));
    end else if (kind < 60) begin
      push_word(SEQ_HORIZ);
      push_word(9'($urandom_range(0, 511)));
      push_word(pick_space_count());
    end else if (kind < 80) begin
      push_word(SEQ_CODE);
      push_word(($urandom_range(0, 9) == 0) ? {2'($urandom_range(0, 3)), KEY_ERASE[6:0]}
                                            : 9'($urandom_range(0, 511)));
    end else if (kind < 88) begin
      // broken sequence: bad kind word or a second start
      push_word(($urandom_range(0, 2) == 0) ? CMD_START : 9'($urandom_range(0, 511)));
    end else begin
      push_word(9'($urandom_range(0, 511)));
    end
  endtask

  initial begin
    int target;
    bit held;
    burst_left = 0;
    steady = 1'b0;
    word_count = 0;
    cur_spc = SPC_RESET;
    cur_lpl = LPL_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(CORNER_WORDS); i++) push_word(CORNER_WORDS[i]);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      held = 1'b0;
      case (phase)
        0: ;
        1: set_regs(8'd1, 8'd0, 1'b1);
        2: set_regs(8'd255, 8'd31, 1'b0);
        3: begin
          write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
          set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 1'b1);
        end
        default: set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
      endcase
      target = word_count + ITEMS_PER_PHASE;
      while (word_count < target) begin
        send_sequence();
        if (word_count >= target - ITEMS_PER_PHASE / 2 && !steady && !held &&
            (phase == 1 || phase == 4)) begin
          // long output hold-off while input keeps coming with no gaps
          held = 1'b1;
          hold_cnt <= hold_cnt + 1;
          steady = 1'b1;
          repeat (12) send_sequence();
          steady = 1'b0;
          target = word_count + ITEMS_PER_PHASE / 4;
        end
        if (phase == 3 && word_count == target - ITEMS_PER_PHASE / 2) wait_idle();
      end
    end

    wait_idle();
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
